@@ rtl/wsp_pkg.sv @@
// Shared constants, widths and the segment record for the wall segment point sampler.
package wsp_pkg;

   localparam int MAX_CORNERS = 64;
   localparam int MAX_SUBDIV  = 63;

   localparam int CORNER_AW = $clog2(MAX_CORNERS);
   localparam int CNT_W     = $clog2(MAX_CORNERS + 1);
   localparam int SUB_W     = $clog2(MAX_SUBDIV + 1);
   localparam int DIV_W     = SUB_W + 1;
   localparam int MAG_W     = 33;
   localparam int QUO_W     = MAG_W + 1;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int L2_W      = SQ_W + 1;
   localparam int SUM_W     = 64 + 2 * SUB_W;
   localparam int STEP_W    = $clog2(QUO_W + 1);

   localparam logic [31:0] SPACING_RESET = 32'h0001_0000;

   // One classified segment handed from the front end to the emitter.
   typedef struct packed {
      logic [31:0]      sx;
      logic [31:0]      sy;
      logic [31:0]      ex;
      logic [31:0]      ey;
      logic [SUB_W-1:0] n;
      logic             capped;
      logic             zero;
      logic             neg_x;
      logic             neg_y;
      logic [QUO_W-1:0] quo_x;
      logic [QUO_W-1:0] quo_y;
      logic [DIV_W-1:0] rem_x;
      logic [DIV_W-1:0] rem_y;
   } seg_type;

endpackage

@@ rtl/wall_segment_point_sampler_core.sv @@
// Top level of the wall segment point sampler: register, front end, queue, emitter.
//
//   channel | direction | fields
//   req_    | in        | start_x, start_y, end_x, end_y
//   rsp_    | out       | point_x, point_y, point_number, last, flags
//   csr_    | in        | point_spacing
//
// The front end runs its bit-serial squarers, then the subdivision search (at most 63
// subdivisions) and then the step divider for each segment.
// The emitter then reads the corner RAM one entry a cycle (up to 64) and sends one
// point a cycle while rsp_tready is high. A two-entry queue lets both ends overlap.
// Reset clears the corner count, point number and spacing; no clearing pass is needed.
module wall_segment_point_sampler_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // start_x, start_y, end_x, end_y
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // point_x, point_y, point_number
   output logic         rsp_tlast,
   output logic [2:0]   rsp_tuser,   // is_corner, subdivision_capped, corner_table_full
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   logic [31:0]      spacing_ff;
   logic             push_valid, push_ready, q_valid, q_ready;
   wsp_pkg::seg_type push_seg, q_seg;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= wsp_pkg::SPACING_RESET;
      end else if (csr_valid) begin
         spacing_ff <= csr_data;
      end
   end

   wsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .spacing    (spacing_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_seg   (push_seg)
   );

   wsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_seg   (push_seg),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_seg   (q_seg)
   );

   wsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_seg      (q_seg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/wsp_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module wsp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/wsp_front.sv @@
// Front end: accepts segments, finds the squared length, the subdivision count
// and the per-axis step quotients, then hands a record to the queue.
module wsp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           spacing,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [127:0]          in_data,
   output logic                  push_valid,
   input  logic                  push_ready,
   output wsp_pkg::seg_type      push_seg
);

   typedef enum logic [2:0] {F_IDLE, F_MUL, F_SRCH, F_DIV, F_PUSH} fstate_type;

   fstate_type                      state_ff, state_in;
   logic [5:0]                      cnt_ff, cnt_in;
   wsp_pkg::seg_type                seg_ff, seg_in;
   logic [wsp_pkg::SQ_W-1:0]        mc_ff [3];
   logic [wsp_pkg::SQ_W-1:0]        mc_in [3];
   logic [wsp_pkg::MAG_W-1:0]       mp_ff [3];
   logic [wsp_pkg::MAG_W-1:0]       mp_in [3];
   logic [wsp_pkg::SQ_W-1:0]        acc_ff [3];
   logic [wsp_pkg::SQ_W-1:0]        acc_in [3];
   logic [wsp_pkg::L2_W-1:0]        l2_ff, l2_in;
   logic [63:0]                     s2_ff, s2_in;
   logic [wsp_pkg::SUM_W-1:0]       sum_ff, sum_in, step_ff, step_in;
   logic [wsp_pkg::SUB_W-1:0]       j_ff, j_in;
   logic [wsp_pkg::QUO_W-1:0]       dvx_ff, dvx_in, dvy_ff, dvy_in;
   logic [wsp_pkg::DIV_W-1:0]       rmx_ff, rmx_in, rmy_ff, rmy_in;

   logic signed [32:0]              dx, dy;
   logic [wsp_pkg::MAG_W-1:0]       ax, ay;
   logic [wsp_pkg::MAG_W-1:0]       seg_dx, seg_dy, mag_x, mag_y;
   logic [wsp_pkg::L2_W-1:0]        l2_sum;
   logic [wsp_pkg::SUM_W-1:0]       step_next;
   logic [wsp_pkg::DIV_W-1:0]       dvsr;
   logic [wsp_pkg::DIV_W:0]         trial_x, trial_y;

   assign in_ready   = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_seg   = seg_ff;

   always_comb begin
      dx = $signed({in_data[95], in_data[95:64]}) - $signed({in_data[31], in_data[31:0]});
      dy = $signed({in_data[127], in_data[127:96]}) - $signed({in_data[63], in_data[63:32]});
      ax = dx[32] ? wsp_pkg::MAG_W'(-dx) : wsp_pkg::MAG_W'(dx);
      ay = dy[32] ? wsp_pkg::MAG_W'(-dy) : wsp_pkg::MAG_W'(dy);
      // The stored endpoints are signed, so the difference needs a sign bit.
      seg_dx    = {seg_ff.ex[31], seg_ff.ex} - {seg_ff.sx[31], seg_ff.sx};
      seg_dy    = {seg_ff.ey[31], seg_ff.ey} - {seg_ff.sy[31], seg_ff.sy};
      mag_x     = seg_ff.neg_x ? -seg_dx : seg_dx;
      mag_y     = seg_ff.neg_y ? -seg_dy : seg_dy;
      l2_sum    = {1'b0, acc_ff[0]} + {1'b0, acc_ff[1]};
      step_next = step_ff + {{(wsp_pkg::SUM_W - 65){1'b0}}, s2_ff, 1'b0};
      dvsr      = {seg_ff.n, 1'b0};
      trial_x   = {rmx_ff, dvx_ff[wsp_pkg::QUO_W-1]};
      trial_y   = {rmy_ff, dvy_ff[wsp_pkg::QUO_W-1]};
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      seg_in   = seg_ff;
      l2_in    = l2_ff;
      s2_in    = s2_ff;
      sum_in   = sum_ff;
      step_in  = step_ff;
      j_in     = j_ff;
      dvx_in   = dvx_ff;
      dvy_in   = dvy_ff;
      rmx_in   = rmx_ff;
      rmy_in   = rmy_ff;
      for (int i = 0; i < 3; i++) begin
         mc_in[i]  = mc_ff[i];
         mp_in[i]  = mp_ff[i];
         acc_in[i] = acc_ff[i];
      end
      unique case (state_ff)
         F_IDLE: begin
            if (in_valid) begin
               seg_in.sx    = in_data[31:0];
               seg_in.sy    = in_data[63:32];
               seg_in.ex    = in_data[95:64];
               seg_in.ey    = in_data[127:96];
               seg_in.neg_x = dx[32];
               seg_in.neg_y = dy[32];
               seg_in.capped = 1'b0;
               seg_in.zero   = 1'b0;
               mc_in[0] = {{(wsp_pkg::SQ_W - wsp_pkg::MAG_W){1'b0}}, ax};
               mc_in[1] = {{(wsp_pkg::SQ_W - wsp_pkg::MAG_W){1'b0}}, ay};
               mc_in[2] = {{(wsp_pkg::SQ_W - 32){1'b0}}, spacing};
               mp_in[0] = ax;
               mp_in[1] = ay;
               mp_in[2] = {1'b0, spacing};
               for (int i = 0; i < 3; i++) begin
                  acc_in[i] = '0;
               end
               cnt_in   = '0;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            // Three shift-and-add squarers run side by side, one bit a cycle.
            for (int i = 0; i < 3; i++) begin
               if (mp_ff[i][0]) begin
                  acc_in[i] = acc_ff[i] + mc_ff[i];
               end
               mc_in[i] = {mc_ff[i][wsp_pkg::SQ_W-2:0], 1'b0};
               mp_in[i] = {1'b0, mp_ff[i][wsp_pkg::MAG_W-1:1]};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(wsp_pkg::MAG_W)) begin
               l2_in   = l2_sum;
               s2_in   = acc_ff[2][63:0];
               sum_in  = {{(wsp_pkg::SUM_W - 64){1'b0}}, acc_ff[2][63:0]};
               step_in = {{(wsp_pkg::SUM_W - 64){1'b0}}, acc_ff[2][63:0]};
               j_in    = wsp_pkg::SUB_W'(1);
               if (l2_sum == '0) begin
                  seg_in.zero = 1'b1;
                  seg_in.n    = '0;
                  state_in    = F_PUSH;
               end else begin
                  state_in = F_SRCH;
               end
            end
         end
         F_SRCH: begin
            // sum holds (j * spacing)^2, grown by odd multiples of spacing^2.
            if (sum_ff >= {{(wsp_pkg::SUM_W - wsp_pkg::L2_W){1'b0}}, l2_ff}) begin
               seg_in.n = j_ff;
               state_in = F_DIV;
            end else if (j_ff == wsp_pkg::SUB_W'(wsp_pkg::MAX_SUBDIV)) begin
               seg_in.n      = j_ff;
               seg_in.capped = 1'b1;
               state_in      = F_DIV;
            end else begin
               step_in = step_next;
               sum_in  = sum_ff + step_next;
               j_in    = j_ff + wsp_pkg::SUB_W'(1);
            end
            dvx_in = {mag_x, 1'b0};
            dvy_in = {mag_y, 1'b0};
            rmx_in = '0;
            rmy_in = '0;
            cnt_in = '0;
         end
         F_DIV: begin
            // Restoring division of twice the magnitude by 2n on both axes.
            if (trial_x >= {1'b0, dvsr}) begin
               rmx_in = wsp_pkg::DIV_W'(trial_x - {1'b0, dvsr});
               dvx_in = {dvx_ff[wsp_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rmx_in = wsp_pkg::DIV_W'(trial_x);
               dvx_in = {dvx_ff[wsp_pkg::QUO_W-2:0], 1'b0};
            end
            if (trial_y >= {1'b0, dvsr}) begin
               rmy_in = wsp_pkg::DIV_W'(trial_y - {1'b0, dvsr});
               dvy_in = {dvy_ff[wsp_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rmy_in = wsp_pkg::DIV_W'(trial_y);
               dvy_in = {dvy_ff[wsp_pkg::QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(wsp_pkg::QUO_W - 1)) begin
               seg_in.quo_x = dvx_in;
               seg_in.quo_y = dvy_in;
               seg_in.rem_x = rmx_in;
               seg_in.rem_y = rmy_in;
               state_in     = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      seg_ff  <= seg_in;
      l2_ff   <= l2_in;
      s2_ff   <= s2_in;
      sum_ff  <= sum_in;
      step_ff <= step_in;
      j_ff    <= j_in;
      dvx_ff  <= dvx_in;
      dvy_ff  <= dvy_in;
      rmx_ff  <= rmx_in;
      rmy_ff  <= rmy_in;
      for (int i = 0; i < 3; i++) begin
         mc_ff[i]  <= mc_in[i];
         mp_ff[i]  <= mp_in[i];
         acc_ff[i] <= acc_in[i];
      end
   end

endmodule

@@ rtl/wsp_queue.sv @@
// Two-entry queue of classified segments between the front end and the emitter.
module wsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  wsp_pkg::seg_type wr_seg,
   output logic             rd_valid,
   input  logic             rd_ready,
   output wsp_pkg::seg_type rd_seg
);

   wsp_pkg::seg_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_wr, do_rd;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_seg   = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_seg;
      end
   end

endmodule

@@ rtl/wsp_back.sv @@
// Emitter: searches the corner table, records new corners and sends the points.
module wsp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  wsp_pkg::seg_type q_seg,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [95:0]      rsp_tdata,
   output logic             rsp_tlast,
   output logic [2:0]       rsp_tuser
);

   typedef enum logic [2:0] {B_IDLE, B_SRCH, B_START, B_MID, B_END} bstate_type;

   bstate_type                    state_ff, state_in;
   wsp_pkg::seg_type              seg_ff, seg_in;
   logic [wsp_pkg::CNT_W-1:0]     total_ff, total_in, rd_idx_ff, rd_idx_in;
   logic                          pend_ff, pend_in;
   logic                          sfound_ff, sfound_in, efound_ff, efound_in;
   logic                          emit_end_ff, emit_end_in;
   logic [wsp_pkg::SUB_W-1:0]     j_ff, j_in;
   logic [wsp_pkg::QUO_W-1:0]     qx_ff, qx_in, qy_ff, qy_in;
   logic [wsp_pkg::DIV_W:0]       rx_ff, rx_in, ry_ff, ry_in;
   logic [31:0]                   ptotal_ff, ptotal_in;
   logic                          ovalid_ff, ovalid_in, olast_ff, olast_in;
   logic [95:0]                   odata_ff, odata_in;
   logic [2:0]                    ouser_ff, ouser_in;

   logic                          can_load, has_mid, tbl_full, srch_done, wr_en;
   logic [wsp_pkg::CORNER_AW-1:0] rd_addr;
   logic [63:0]                   rd_data, wr_data;
   logic [wsp_pkg::DIV_W:0]       dvsr, rx_sum, ry_sum, rx_nx, ry_nx;
   logic [wsp_pkg::QUO_W-1:0]     qx_nx, qy_nx;
   logic [31:0]                   px, py;

   wsp_ram #(
      .WIDTH (64),
      .DEPTH (wsp_pkg::MAX_CORNERS)
   ) u_corner_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (total_ff[wsp_pkg::CORNER_AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign q_ready    = (state_ff == B_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = ouser_ff;

   always_comb begin
      can_load  = !ovalid_ff || rsp_tready;
      has_mid   = !seg_ff.zero && (seg_ff.n > wsp_pkg::SUB_W'(1));
      tbl_full  = (total_ff == wsp_pkg::CNT_W'(wsp_pkg::MAX_CORNERS));
      srch_done = (rd_idx_ff == total_ff) && !pend_ff;
      rd_addr   = rd_idx_ff[wsp_pkg::CORNER_AW-1:0];
      // Next interior point: add the whole and fractional step, carry once.
      dvsr   = {1'b0, seg_ff.n, 1'b0};
      rx_sum = rx_ff + {1'b0, seg_ff.rem_x};
      ry_sum = ry_ff + {1'b0, seg_ff.rem_y};
      qx_nx  = qx_ff + seg_ff.quo_x + wsp_pkg::QUO_W'(rx_sum >= dvsr);
      qy_nx  = qy_ff + seg_ff.quo_y + wsp_pkg::QUO_W'(ry_sum >= dvsr);
      rx_nx  = (rx_sum >= dvsr) ? rx_sum - dvsr : rx_sum;
      ry_nx  = (ry_sum >= dvsr) ? ry_sum - dvsr : ry_sum;
      px = seg_ff.neg_x ? seg_ff.sx - qx_nx[31:0] : seg_ff.sx + qx_nx[31:0];
      py = seg_ff.neg_y ? seg_ff.sy - qy_nx[31:0] : seg_ff.sy + qy_nx[31:0];
   end

   always_comb begin
      state_in    = state_ff;
      seg_in      = seg_ff;
      total_in    = total_ff;
      rd_idx_in   = rd_idx_ff;
      pend_in     = pend_ff;
      sfound_in   = sfound_ff;
      efound_in   = efound_ff;
      emit_end_in = emit_end_ff;
      j_in        = j_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      ptotal_in   = ptotal_ff;
      ovalid_in   = ovalid_ff && !rsp_tready;
      olast_in    = olast_ff;
      odata_in    = odata_ff;
      ouser_in    = ouser_ff;
      wr_en       = 1'b0;
      wr_data     = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               seg_in    = q_seg;
               rd_idx_in = '0;
               pend_in   = 1'b0;
               sfound_in = 1'b0;
               efound_in = 1'b0;
               qx_in     = '0;
               qy_in     = '0;
               rx_in     = {2'b0, q_seg.n};
               ry_in     = {2'b0, q_seg.n};
               j_in      = wsp_pkg::SUB_W'(1);
               state_in  = B_SRCH;
            end
         end
         B_SRCH: begin
            if (rd_idx_ff != total_ff) begin
               rd_idx_in = rd_idx_ff + wsp_pkg::CNT_W'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (rd_data == {seg_ff.sy, seg_ff.sx}) sfound_in = 1'b1;
               if (rd_data == {seg_ff.ey, seg_ff.ex}) efound_in = 1'b1;
            end
            if (srch_done) begin
               // The end point also matches a start point recorded just before it.
               emit_end_in = !seg_ff.zero && !efound_ff &&
                             !(!sfound_ff && !tbl_full &&
                               seg_ff.ex == seg_ff.sx && seg_ff.ey == seg_ff.sy);
               if (!sfound_ff) state_in = B_START;
               else if (has_mid) state_in = B_MID;
               else if (emit_end_in) state_in = B_END;
               else state_in = B_IDLE;
            end
         end
         B_START: begin
            if (can_load) begin
               ovalid_in = 1'b1;
               odata_in  = {ptotal_ff, seg_ff.sy, seg_ff.sx};
               olast_in  = !has_mid && !emit_end_ff;
               ouser_in  = {tbl_full, seg_ff.capped, !tbl_full};
               ptotal_in = ptotal_ff + 32'd1;
               if (!tbl_full) begin
                  wr_en    = 1'b1;
                  wr_data  = {seg_ff.sy, seg_ff.sx};
                  total_in = total_ff + wsp_pkg::CNT_W'(1);
               end
               if (has_mid) state_in = B_MID;
               else if (emit_end_ff) state_in = B_END;
               else state_in = B_IDLE;
            end
         end
         B_MID: begin
            if (can_load) begin
               ovalid_in = 1'b1;
               odata_in  = {ptotal_ff, py, px};
               olast_in  = (j_ff == seg_ff.n - wsp_pkg::SUB_W'(1)) && !emit_end_ff;
               ouser_in  = {1'b0, seg_ff.capped, 1'b0};
               ptotal_in = ptotal_ff + 32'd1;
               qx_in     = qx_nx;
               qy_in     = qy_nx;
               rx_in     = rx_nx;
               ry_in     = ry_nx;
               j_in      = j_ff + wsp_pkg::SUB_W'(1);
               if (j_ff == seg_ff.n - wsp_pkg::SUB_W'(1)) begin
                  state_in = emit_end_ff ? B_END : B_IDLE;
               end
            end
         end
         B_END: begin
            if (can_load) begin
               ovalid_in = 1'b1;
               odata_in  = {ptotal_ff, seg_ff.ey, seg_ff.ex};
               olast_in  = 1'b1;
               ouser_in  = {tbl_full, seg_ff.capped, !tbl_full};
               ptotal_in = ptotal_ff + 32'd1;
               if (!tbl_full) begin
                  wr_en    = 1'b1;
                  wr_data  = {seg_ff.ey, seg_ff.ex};
                  total_in = total_ff + wsp_pkg::CNT_W'(1);
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         total_ff  <= '0;
         ptotal_ff <= '0;
         ovalid_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         total_ff  <= total_in;
         ptotal_ff <= ptotal_in;
         ovalid_ff <= ovalid_in;
         pend_ff   <= pend_in;
      end
      seg_ff      <= seg_in;
      rd_idx_ff   <= rd_idx_in;
      sfound_ff   <= sfound_in;
      efound_ff   <= efound_in;
      emit_end_ff <= emit_end_in;
      j_ff        <= j_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      olast_ff    <= olast_in;
      odata_ff    <= odata_in;
      ouser_ff    <= ouser_in;
   end

endmodule

@@ bench/tb_wall_segment_point_sampler_core.sv @@
// Self-checking testbench for the wall segment point sampler core.
`timescale 1ns / 100ps

module tb_wall_segment_point_sampler_core;

   localparam int POOL_SIZE  = 24;
   localparam int PHASE_SEGS = 94;
   localparam int IDLE_LIMIT = 6000;
   localparam int SETTLE     = 300;
   localparam int HOLD_OFF   = 1500;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] num;
      logic        corner;
      logic        last;
      logic        capped;
      logic        full;
   } wall_point_type;

   typedef struct {
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] ex;
      logic [31:0] ey;
      int          point_count;   // -1 where only the predictor decides
   } segment_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic         rsp_tlast;
   logic [2:0]   rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [31:0]  csr_data;

   // Shadow state of the block.
   logic [31:0] spacing;
   logic [31:0] corner_x [wsp_pkg::MAX_CORNERS];
   logic [31:0] corner_y [wsp_pkg::MAX_CORNERS];
   int          corner_count;
   logic [31:0] point_count;
   wall_point_type expected_points[$];

   logic [31:0] pool_x [POOL_SIZE];
   logic [31:0] pool_y [POOL_SIZE];
   int          sender_idle_pct;
   int          receiver_stall_pct;
   bit          hold_request;
   int          hold_cycles;
   int          errors;
   int          quiet_cycles;

   wall_segment_point_sampler_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic void record_point(logic [31:0] x, logic [31:0] y, logic corner,
                                        logic capped, logic full);
      wall_point_type p;
      p.x      = x;
      p.y      = y;
      p.num    = point_count;
      p.corner = corner;
      p.last   = 1'b0;
      p.capped = capped;
      p.full   = full;
      expected_points.push_back(p);
      point_count = point_count + 32'd1;
   endfunction

   // An endpoint is emitted only when it is not in the corner table yet.
   function automatic void add_endpoint(logic [31:0] x, logic [31:0] y, logic capped);
      for (int i = 0; i < corner_count; i++)
         if (corner_x[i] == x && corner_y[i] == y)
            return;
      if (corner_count < wsp_pkg::MAX_CORNERS) begin
         corner_x[corner_count] = x;
         corner_y[corner_count] = y;
         corner_count++;
         record_point(x, y, 1'b1, capped, 1'b0);
      end else begin
         record_point(x, y, 1'b0, capped, 1'b1);
      end
   endfunction

   // Rounded point j of n along one axis, ties away from zero.
   function automatic logic [31:0] axis_step(logic [31:0] s, longint d, int j, int n);
      longint unsigned mag;
      longint unsigned q;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      q   = (longint'(j) * mag * 2 + longint'(n)) / (2 * longint'(n));
      return (d < 0) ? s - q[31:0] : s + q[31:0];
   endfunction

   // Works out the wall points of one segment; returns how many it causes.
   function automatic int sample_segment(logic [31:0] sx, logic [31:0] sy,
                                         logic [31:0] ex, logic [31:0] ey);
      longint       dx;
      longint       dy;
      logic [127:0] ax;
      logic [127:0] ay;
      logic [127:0] len_sq;
      logic [127:0] span;
      int           first;
      int           n;
      logic         capped;
      first  = expected_points.size();
      dx     = longint'($signed(ex)) - longint'($signed(sx));
      dy     = longint'($signed(ey)) - longint'($signed(sy));
      ax     = (dx < 0) ? 128'(-dx) : 128'(dx);
      ay     = (dy < 0) ? 128'(-dy) : 128'(dy);
      len_sq = ax * ax + ay * ay;
      n      = 0;
      capped = 1'b0;
      if (len_sq == 0) begin
         add_endpoint(sx, sy, 1'b0);
      end else begin
         for (int j = 1; j <= wsp_pkg::MAX_SUBDIV; j++) begin
            span = 128'(j) * 128'(spacing);
            if (span * span >= len_sq) begin
               n = j;
               break;
            end
         end
         if (n == 0) begin
            n      = wsp_pkg::MAX_SUBDIV;
            capped = 1'b1;
         end
         add_endpoint(sx, sy, capped);
         for (int j = 1; j < n; j++)
            record_point(axis_step(sx, dx, j, n), axis_step(sy, dy, j, n),
                         1'b0, capped, 1'b0);
         add_endpoint(ex, ey, capped);
      end
      if (expected_points.size() > first)
         expected_points[$].last = 1'b1;
      return expected_points.size() - first;
   endfunction

   task automatic send_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                               logic [31:0] ey, int point_total_typed);
      bit taken;
      int caused;
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ey, ex, sy, sx};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      caused = sample_segment(sx, sy, ex, ey);
      if (point_total_typed >= 0 && caused != point_total_typed) begin
         $display("%0t: segment %h,%h -> %h,%h: expected %0d points, predicted %0d",
                  $time, sx, sy, ex, ey, point_total_typed, caused);
         errors++;
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_points.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_spacing(logic [31:0] value);
      bit taken;
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      spacing = value;
   endtask

   function automatic void pick_point(output logic [31:0] x, output logic [31:0] y);
      int k;
      case ($urandom_range(3))
         0, 1: begin
            k = $urandom_range(POOL_SIZE - 1);
            x = pool_x[k];
            y = pool_y[k];
         end
         2: begin
            x = $urandom;
            y = $urandom;
         end
         default: begin
            x = ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            y = ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
      endcase
   endfunction

   task automatic random_segments(int count);
      logic [31:0]        sx;
      logic [31:0]        sy;
      logic [31:0]        ex;
      logic [31:0]        ey;
      logic signed [31:0] offset;
      int                 pick;
      for (int i = 0; i < count; i++) begin
         pick_point(sx, sy);
         pick = $urandom_range(99);
         if (pick < 5) begin
            ex = sx;
            ey = sy;
         end else if (pick < 45) begin
            pick_point(ex, ey);
         end else begin
            // Short and long spans alike, from a random shift of a signed offset.
            offset = $signed($urandom) >>> $urandom_range(31);
            ex     = sx + offset;
            offset = $signed($urandom) >>> $urandom_range(31);
            ey     = sy + offset;
         end
         send_segment(sx, sy, ex, ey, -1);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_cycles  = HOLD_OFF;
         rsp_tready  <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Outputs are stable at the falling edge; a transfer seen here happens at the next rise.
   always @(negedge clock) begin
      wall_point_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: point %h,%h #%0d arrived with nothing expected",
                        $time, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64]);
               errors++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_tdata !== {want.num, want.y, want.x} ||
                   rsp_tlast !== want.last ||
                   rsp_tuser !== {want.full, want.capped, want.corner}) begin
                  $display("%0t: expected x=%h y=%h num=%0d last=%b full/capped/corner=%b%b%b",
                           $time, want.x, want.y, want.num, want.last,
                           want.full, want.capped, want.corner);
                  $display("%0t:   actual x=%h y=%h num=%0d last=%b full/capped/corner=%b",
                           $time, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                           rsp_tlast, rsp_tuser);
                  errors++;
               end
            end
         end
      end
   end

   segment_row_type directed_rows[] = '{
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1},  // new point
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0},  // known point
      '{32'h0000_0000, 32'h0000_0000, 32'h0002_0000, 32'h0000_0000, 2},
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000, 1},  // under spacing
      '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64}, // capped
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 62},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 64},
      '{32'hFFFD_0000, 32'h0001_0000, 32'hFFFA_8000, 32'hFFFE_0000, -1},
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0003, 32'hFFFF_FFFD, -1},
      '{32'h0000_0001, 32'h0000_0000, 32'h0003_0000, 32'h0001_8001, -1},
      '{32'h0003_0000, 32'h0001_8001, 32'h0000_0001, 32'h0000_0000, 3},  // exact match
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0005_0000, -1},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1}
   };

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      rsp_tready         = 1'b0;
      csr_valid          = 1'b0;
      csr_data           = '0;
      hold_request       = 1'b0;
      hold_cycles        = 0;
      errors             = 0;
      quiet_cycles       = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      spacing            = wsp_pkg::SPACING_RESET;
      corner_count       = 0;
      point_count        = '0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_x[i] = $signed($urandom) >>> 10;
         pool_y[i] = $signed($urandom) >>> 10;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_segment(directed_rows[i].sx, directed_rows[i].sy, directed_rows[i].ex,
                      directed_rows[i].ey, directed_rows[i].point_count);

      // No idling; the long receiver hold-off fills the block up.
      random_segments(20);
      hold_request = 1'b1;
      random_segments(PHASE_SEGS - 20);
      drain();

      write_spacing(32'h0000_0001);
      sender_idle_pct = 47;
      random_segments(PHASE_SEGS);
      drain();

      write_spacing(32'hFFFF_FFFF);
      sender_idle_pct    = 0;
      receiver_stall_pct = 47;
      random_segments(PHASE_SEGS);
      drain();

      write_spacing(32'h0040_0000);
      sender_idle_pct    = 25;
      receiver_stall_pct = 25;
      random_segments(PHASE_SEGS);
      drain();

      write_spacing(32'h0000_0001 << $urandom_range(31) | $urandom_range(65535));
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      random_segments(PHASE_SEGS);
      drain();

      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/wsp_pkg.sv
rtl/wsp_ram.sv
rtl/wsp_front.sv
rtl/wsp_queue.sv
rtl/wsp_back.sv
rtl/wall_segment_point_sampler_core.sv
bench/tb_wall_segment_point_sampler_core.sv
